[hw/rtl/prr_pkg.sv]
// package: shared types and constants of the pinhole reprojection residual block
`default_nettype none
package prr_pkg;

  // fixed point format of pixel and metric values
  localparam int unsigned FracBits = 16;

  // register reset values
  localparam logic [30:0] FocalXRst   = 31'd32768000;
  localparam logic [30:0] FocalYRst   = 31'd32768000;
  localparam logic [31:0] CenterXRst  = 32'd20971520;
  localparam logic [31:0] CenterYRst  = 32'd15728640;
  localparam logic [31:0] SkewRst     = 32'd0;
  localparam logic [30:0] MinDepthRst = 31'((((64'd1 << FracBits) + 64'd5) / 64'd10));

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgFocalX   = 3'd0,
    CfgFocalY   = 3'd1,
    CfgCenterX  = 3'd2,
    CfgCenterY  = 3'd3,
    CfgSkew     = 3'd4,
    CfgMinDepth = 3'd5
  } cfg_idx_e;

  // divider geometry: quotient bits kept, bits resolved per stage
  localparam int unsigned QuotBits  = 42;
  localparam int unsigned DivSteps  = 2;
  localparam int unsigned DivStages = QuotBits / DivSteps;

  // one lane of the restoring divider
  typedef struct packed {
    logic [30:0]         rem;
    logic [QuotBits-1:0] sh;
  } div_lane_t;

  // side data that travels with the divider lanes
  typedef struct packed {
    logic               front;
    logic               ovf_u;
    logic               ovf_v;
    logic               neg_u;
    logic               neg_v;
    logic [30:0]        dvs;
    logic signed [31:0] obs_u;
    logic signed [31:0] obs_v;
  } div_side_t;

endpackage
`default_nettype wire

[hw/rtl/pinhole_reprojection_residual.sv]
// top level: pipelined pinhole camera reprojection residual
//
// input channel: one beat per observation (pose quaternion Q2.30, translation,
// world point and observed pixel in Q16.16), in_valid_i / in_stall_o.
// output channel: one beat per input beat, same order, carrying the saturated
// Q16.16 residual pair and the in_front flag, out_valid_o / out_stall_i.
// config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock
// edge; unknown indexes are ignored. write only while the pipeline is empty.
// throughput: one beat per cycle while no output beat is held. the pipeline is
// six arithmetic stages, a divider entry stage, 21 radix-4 restoring divider
// stages and two output stages.
// a receiver stall of a valid output beat freezes the whole pipeline in place and
// raises in_stall_o in the same cycle; nothing is dropped or repeated.
// reset clears all valid bits and loads the register defaults (focal 500.0,
// center 320.0 / 240.0, skew 0, min depth 0.1).
`default_nettype none
module pinhole_reprojection_residual import prr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] rot_qx_i,
  input  wire logic signed [31:0] rot_qy_i,
  input  wire logic signed [31:0] rot_qz_i,
  input  wire logic signed [31:0] rot_qw_i,
  input  wire logic signed [31:0] trans_x_i,
  input  wire logic signed [31:0] trans_y_i,
  input  wire logic signed [31:0] trans_z_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  input  wire logic signed [31:0] obs_u_i,
  input  wire logic signed [31:0] obs_v_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      res_u_o,
  output logic signed [31:0]      res_v_o,
  output logic                    in_front_o
);

  localparam logic signed [37:0] OneQ30  = 38'sd1073741824;
  localparam logic signed [42:0] QuotLim = 43'sd1099511627776;

  // round half up and drop 30 fraction bits
  function automatic logic signed [33:0] shr30(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + 64'sd536870912;
    return t[63:30];
  endfunction

  // clamp a rotation entry to [-1.0, +1.0]
  function automatic logic signed [31:0] sat_rot(input logic signed [37:0] x);
    if (x > OneQ30) return 32'sd1073741824;
    else if (x < -OneQ30) return -32'sd1073741824;
    else return x[31:0];
  endfunction

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
    if (x > 45'sd2147483647) return 32'sh7fffffff;
    else if (x < -45'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  // one restoring division step
  function automatic div_lane_t div_step(input div_lane_t a, input logic [30:0] dvs);
    div_lane_t   r;
    logic [31:0] t;
    t = {a.rem, a.sh[QuotBits-1]};
    if (t >= {1'b0, dvs}) begin
      r.rem = 31'(t - {1'b0, dvs});
      r.sh  = {a.sh[QuotBits-2:0], 1'b1};
    end else begin
      r.rem = t[30:0];
      r.sh  = {a.sh[QuotBits-2:0], 1'b0};
    end
    return r;
  endfunction

  // configuration registers
  logic [30:0]        focal_x_q, focal_y_q, min_depth_q;
  logic signed [31:0] center_x_q, center_y_q, skew_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q   <= FocalXRst;
      focal_y_q   <= FocalYRst;
      center_x_q  <= CenterXRst;
      center_y_q  <= CenterYRst;
      skew_q      <= SkewRst;
      min_depth_q <= MinDepthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFocalX:   focal_x_q   <= cfg_data_i[30:0];
        CfgFocalY:   focal_y_q   <= cfg_data_i[30:0];
        CfgCenterX:  center_x_q  <= cfg_data_i;
        CfgCenterY:  center_y_q  <= cfg_data_i;
        CfgSkew:     skew_q      <= cfg_data_i;
        CfgMinDepth: min_depth_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the output beat is held
  logic adv;
  assign in_stall_o = out_valid_o & out_stall_i;
  assign adv        = ~in_stall_o;

  // valid bits
  logic                s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, f1_v_q, f2_v_q;
  logic [DivStages:0]  dv_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0; s4_v_q <= 1'b0;
      s5_v_q <= 1'b0; s6_v_q <= 1'b0; f1_v_q <= 1'b0; f2_v_q <= 1'b0;
      dv_v_q <= '0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      dv_v_q <= {dv_v_q[DivStages-1:0], s6_v_q};
      f1_v_q <= dv_v_q[DivStages];
      f2_v_q <= f1_v_q;
    end
  end

  // stage 1: quaternion pair products
  logic signed [63:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  logic signed [31:0] s1_t_q [3];
  logic signed [31:0] s1_p_q [3];
  logic signed [31:0] s1_ou_q, s1_ov_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q <= rot_qx_i * rot_qx_i;
      yy_q <= rot_qy_i * rot_qy_i;
      zz_q <= rot_qz_i * rot_qz_i;
      xy_q <= rot_qx_i * rot_qy_i;
      xz_q <= rot_qx_i * rot_qz_i;
      yz_q <= rot_qy_i * rot_qz_i;
      xw_q <= rot_qx_i * rot_qw_i;
      yw_q <= rot_qy_i * rot_qw_i;
      zw_q <= rot_qz_i * rot_qw_i;
      s1_t_q[0] <= trans_x_i; s1_t_q[1] <= trans_y_i; s1_t_q[2] <= trans_z_i;
      s1_p_q[0] <= point_x_i; s1_p_q[1] <= point_y_i; s1_p_q[2] <= point_z_i;
      s1_ou_q <= obs_u_i;
      s1_ov_q <= obs_v_i;
    end
  end

  // stage 2: rotation matrix entries
  logic signed [33:0] rxx, ryy, rzz, rxy, rxz, ryz, rxw, ryw, rzw;
  assign rxx = shr30(xx_q); assign ryy = shr30(yy_q); assign rzz = shr30(zz_q);
  assign rxy = shr30(xy_q); assign rxz = shr30(xz_q); assign ryz = shr30(yz_q);
  assign rxw = shr30(xw_q); assign ryw = shr30(yw_q); assign rzw = shr30(zw_q);

  logic signed [31:0] rot_q [9];
  logic signed [31:0] s2_t_q [3];
  logic signed [31:0] s2_p_q [3];
  logic signed [31:0] s2_ou_q, s2_ov_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rot_q[0] <= sat_rot(OneQ30 - ((38'(ryy) + 38'(rzz)) <<< 1));
      rot_q[1] <= sat_rot((38'(rxy) - 38'(rzw)) <<< 1);
      rot_q[2] <= sat_rot((38'(rxz) + 38'(ryw)) <<< 1);
      rot_q[3] <= sat_rot((38'(rxy) + 38'(rzw)) <<< 1);
      rot_q[4] <= sat_rot(OneQ30 - ((38'(rxx) + 38'(rzz)) <<< 1));
      rot_q[5] <= sat_rot((38'(ryz) - 38'(rxw)) <<< 1);
      rot_q[6] <= sat_rot((38'(rxz) - 38'(ryw)) <<< 1);
      rot_q[7] <= sat_rot((38'(ryz) + 38'(rxw)) <<< 1);
      rot_q[8] <= sat_rot(OneQ30 - ((38'(rxx) + 38'(ryy)) <<< 1));
      s2_t_q  <= s1_t_q;
      s2_p_q  <= s1_p_q;
      s2_ou_q <= s1_ou_q;
      s2_ov_q <= s1_ov_q;
    end
  end

  // stage 3: rotation times point products
  logic signed [63:0] rp_q [9];
  logic signed [31:0] s3_t_q [3];
  logic signed [31:0] s3_ou_q, s3_ov_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        rp_q[i] <= rot_q[i] * s2_p_q[i % 3];
      end
      s3_t_q  <= s2_t_q;
      s3_ou_q <= s2_ou_q;
      s3_ov_q <= s2_ov_q;
    end
  end

  // stage 4: camera point, rounded, translated and clamped
  logic signed [31:0] cam_q [3];
  logic signed [31:0] s4_ou_q, s4_ov_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cam_q[i] <= sat32(45'(shr30(rp_q[3*i] + rp_q[3*i+1] + rp_q[3*i+2]))
                          + 45'(s3_t_q[i]));
      end
      s4_ou_q <= s3_ou_q;
      s4_ov_q <= s3_ov_q;
    end
  end

  // stage 5: depth test and intrinsics products
  logic               front;
  logic signed [63:0] fxcx_q, skcy_q, fycy_q;
  logic               s5_front_q;
  logic [30:0]        s5_dvs_q;
  logic signed [31:0] s5_ou_q, s5_ov_q;

  assign front = cam_q[2] > $signed({1'b0, min_depth_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fxcx_q     <= $signed({1'b0, focal_x_q}) * cam_q[0];
      skcy_q     <= skew_q * cam_q[1];
      fycy_q     <= $signed({1'b0, focal_y_q}) * cam_q[1];
      s5_front_q <= front;
      s5_dvs_q   <= front ? cam_q[2][30:0] : 31'd1;
      s5_ou_q    <= s4_ou_q;
      s5_ov_q    <= s4_ov_q;
    end
  end

  // stage 6: numerators to sign and magnitude
  logic signed [64:0] num_u, num_v;
  logic [63:0]        mag_u_q, mag_v_q;
  logic               s6_neg_u_q, s6_neg_v_q, s6_front_q;
  logic [30:0]        s6_dvs_q;
  logic signed [31:0] s6_ou_q, s6_ov_q;

  assign num_u = 65'(fxcx_q) + 65'(skcy_q);
  assign num_v = 65'(fycy_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_u_q    <= num_u[64] ? 64'(-num_u) : num_u[63:0];
      mag_v_q    <= num_v[64] ? 64'(-num_v) : num_v[63:0];
      s6_neg_u_q <= num_u[64];
      s6_neg_v_q <= num_v[64];
      s6_front_q <= s5_front_q;
      s6_dvs_q   <= s5_dvs_q;
      s6_ou_q    <= s5_ou_q;
      s6_ov_q    <= s5_ov_q;
    end
  end

  // divider entry: overflow check on the high part and first partial remainder
  logic [63-QuotBits:0] hi_u, hi_v;
  assign hi_u = mag_u_q[63:QuotBits];
  assign hi_v = mag_v_q[63:QuotBits];

  div_lane_t dl_u_q [DivStages+1];
  div_lane_t dl_v_q [DivStages+1];
  div_side_t ds_q   [DivStages+1];

  // divider entry and divider stages, two quotient bits each
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_u_q[0].rem   <= 31'(hi_u);
      dl_u_q[0].sh    <= mag_u_q[QuotBits-1:0];
      dl_v_q[0].rem   <= 31'(hi_v);
      dl_v_q[0].sh    <= mag_v_q[QuotBits-1:0];
      ds_q[0].front   <= s6_front_q;
      ds_q[0].ovf_u   <= 31'(hi_u) >= s6_dvs_q;
      ds_q[0].ovf_v   <= 31'(hi_v) >= s6_dvs_q;
      ds_q[0].neg_u   <= s6_neg_u_q;
      ds_q[0].neg_v   <= s6_neg_v_q;
      ds_q[0].dvs     <= s6_dvs_q;
      ds_q[0].obs_u   <= s6_ou_q;
      ds_q[0].obs_v   <= s6_ov_q;
      for (int k = 0; k < DivStages; k++) begin
        dl_u_q[k+1] <= div_step(div_step(dl_u_q[k], ds_q[k].dvs), ds_q[k].dvs);
        dl_v_q[k+1] <= div_step(div_step(dl_v_q[k], ds_q[k].dvs), ds_q[k].dvs);
        ds_q[k+1]   <= ds_q[k];
      end
    end
  end

  // output stage 1: floor correction and quotient clamp
  div_lane_t          qu_l, qv_l;
  div_side_t          qs;
  logic [42:0]        qm_u, qm_v;
  logic signed [42:0] quo_u_q, quo_v_q;
  logic               f1_front_q;
  logic signed [31:0] f1_ou_q, f1_ov_q;

  assign qu_l = dl_u_q[DivStages];
  assign qv_l = dl_v_q[DivStages];
  assign qs   = ds_q[DivStages];

  always_comb begin
    qm_u = 43'(qu_l.sh) + 43'(qs.neg_u && (qu_l.rem != '0));
    qm_v = 43'(qv_l.sh) + 43'(qs.neg_v && (qv_l.rem != '0));
    if (qs.ovf_u || (qm_u > 43'(QuotLim))) qm_u = 43'(QuotLim);
    if (qs.ovf_v || (qm_v > 43'(QuotLim))) qm_v = 43'(QuotLim);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quo_u_q    <= qs.neg_u ? -$signed(qm_u) : $signed(qm_u);
      quo_v_q    <= qs.neg_v ? -$signed(qm_v) : $signed(qm_v);
      f1_front_q <= qs.front;
      f1_ou_q    <= qs.obs_u;
      f1_ov_q    <= qs.obs_v;
    end
  end

  // output stage 2: add center, subtract observation, clamp; zero for a point behind the camera
  logic signed [31:0] res_u_q, res_v_q;
  logic               front_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (f1_front_q) begin
        res_u_q <= sat32(45'(quo_u_q) + 45'(center_x_q) - 45'(f1_ou_q));
        res_v_q <= sat32(45'(quo_v_q) + 45'(center_y_q) - 45'(f1_ov_q));
      end else begin
        res_u_q <= '0;
        res_v_q <= '0;
      end
      front_q <= f1_front_q;
    end
  end

  assign out_valid_o = f2_v_q;
  assign res_u_o     = res_u_q;
  assign res_v_o     = res_v_q;
  assign in_front_o  = front_q;

endmodule
`default_nettype wire

[hw/rtl/prr_checker.sv]
// checker: port level properties of the reprojection residual block, with its bind
`default_nettype none
module prr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] res_u_o,
  input wire logic signed [31:0] res_v_o,
  input wire logic               in_front_o
);

  // a held output beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  // a held output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(res_u_o) && $stable(res_v_o)
                                   && $stable(in_front_o))
    else $error("output payload changed under stall");

  // input side stalls exactly when the output beat is held
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to held output beat");

  // a point behind the camera gives zero residuals
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_front_o |-> (res_u_o == '0) && (res_v_o == '0))
    else $error("nonzero residual for point behind camera");

endmodule

bind pinhole_reprojection_residual prr_checker u_prr_checker (.*);
`default_nettype wire

[tb/sv/testbench.sv]
// testbench: random and directed check of the pinhole reprojection residual pipeline
`default_nettype none

// expected residual beat
typedef struct {
  logic signed [31:0] res_u;
  logic signed [31:0] res_v;
  logic               in_front;
} residual_t;

// scoreboard of predicted residuals and their registers
class residual_board;
  logic [30:0] focal_x, focal_y, min_depth;
  logic signed [31:0] center_x, center_y, skew;
  residual_t pending[$];
  int errors;
  int n_front;
  int n_checked;

  function new();
    focal_x = prr_pkg::FocalXRst;
    focal_y = prr_pkg::FocalYRst;
    center_x = prr_pkg::CenterXRst;
    center_y = prr_pkg::CenterYRst;
    skew = prr_pkg::SkewRst;
    min_depth = prr_pkg::MinDepthRst;
    errors = 0;
    n_front = 0;
    n_checked = 0;
  endfunction

  function void write_reg(prr_pkg::cfg_idx_e idx, logic [31:0] data);
    case (idx)
      prr_pkg::CfgFocalX: focal_x = data[30:0];
      prr_pkg::CfgFocalY: focal_y = data[30:0];
      prr_pkg::CfgCenterX: center_x = data;
      prr_pkg::CfgCenterY: center_y = data;
      prr_pkg::CfgSkew: skew = data;
      prr_pkg::CfgMinDepth: min_depth = data[30:0];
      default: ;
    endcase
  endfunction

  static function longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round half up then arithmetic shift by 30
  static function longint rnd30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  static function longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // predict the residual of one accepted input beat
  function void note_input(logic signed [31:0] q[4], logic signed [31:0] t[3],
                           logic signed [31:0] p[3], logic signed [31:0] ou,
                           logic signed [31:0] ov);
    longint one, lim, qlim, xx, yy, zz, xy, xz, yz, xw, yw, zw, acc, au, av, qu, qv;
    longint r[3][3];
    longint c[3];
    residual_t e;
    one = 64'sd1 <<< 30;
    lim = 64'sd1 <<< 31;
    qlim = 64'sd1 <<< 40;
    xx = rnd30(longint'(q[0]) * q[0]); yy = rnd30(longint'(q[1]) * q[1]);
    zz = rnd30(longint'(q[2]) * q[2]); xy = rnd30(longint'(q[0]) * q[1]);
    xz = rnd30(longint'(q[0]) * q[2]); yz = rnd30(longint'(q[1]) * q[2]);
    xw = rnd30(longint'(q[0]) * q[3]); yw = rnd30(longint'(q[1]) * q[3]);
    zw = rnd30(longint'(q[2]) * q[3]);
    r[0][0] = clamp(one - 2 * (yy + zz), -one, one);
    r[0][1] = clamp(2 * (xy - zw), -one, one);
    r[0][2] = clamp(2 * (xz + yw), -one, one);
    r[1][0] = clamp(2 * (xy + zw), -one, one);
    r[1][1] = clamp(one - 2 * (xx + zz), -one, one);
    r[1][2] = clamp(2 * (yz - xw), -one, one);
    r[2][0] = clamp(2 * (xz - yw), -one, one);
    r[2][1] = clamp(2 * (yz + xw), -one, one);
    r[2][2] = clamp(one - 2 * (xx + yy), -one, one);
    for (int i = 0; i < 3; i++) begin
      acc = r[i][0] * p[0] + r[i][1] * p[1] + r[i][2] * p[2];
      c[i] = clamp(rnd30(acc) + t[i], -lim, lim - 1);
    end
    e.res_u = 0;
    e.res_v = 0;
    e.in_front = 1'b0;
    if (c[2] > longint'(min_depth)) begin
      au = longint'(focal_x) * c[0] + longint'(skew) * c[1];
      av = longint'(focal_y) * c[1];
      qu = clamp(fdiv(au, c[2]), -qlim, qlim);
      qv = clamp(fdiv(av, c[2]), -qlim, qlim);
      e.res_u = 32'(clamp(qu + center_x - ou, -lim, lim - 1));
      e.res_v = 32'(clamp(qv + center_y - ov, -lim, lim - 1));
      e.in_front = 1'b1;
    end
    pending = {pending, e};
  endfunction

  // compare one output beat with the oldest prediction
  function void check_result(logic signed [31:0] ru, logic signed [31:0] rv, logic fr);
    residual_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat res_u=%0d res_v=%0d in_front=%0b", $time, ru, rv, fr);
      errors++;
      return;
    end
    e = pending.pop_front();
    n_checked++;
    if (fr) n_front++;
    if (ru !== e.res_u) begin
      $display("%0t: res_u expected %0d actual %0d", $time, e.res_u, ru);
      errors++;
    end
    if (rv !== e.res_v) begin
      $display("%0t: res_v expected %0d actual %0d", $time, e.res_v, rv);
      errors++;
    end
    if (fr !== e.in_front) begin
      $display("%0t: in_front expected %0b actual %0b", $time, e.in_front, fr);
      errors++;
    end
  endfunction
endclass

module testbench;
  import prr_pkg::*;

  localparam int Latency = 30;
  localparam longint CycleLimit = 400000;
  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] rot_qx_i = '0, rot_qy_i = '0, rot_qz_i = '0, rot_qw_i = '0;
  logic signed [31:0] trans_x_i = '0, trans_y_i = '0, trans_z_i = '0;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic signed [31:0] obs_u_i = '0, obs_v_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] res_u_o, res_v_o;
  logic in_front_o;

  residual_board board = new();
  longint cycles = 0;
  int n_sent = 0;
  int stall_left = 0;
  bit quiet_stall = 1'b0;

  pinhole_reprojection_residual dut (.*);

  always #4 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // monitor accepted input and output beats
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      board.note_input('{rot_qx_i, rot_qy_i, rot_qz_i, rot_qw_i},
                       '{trans_x_i, trans_y_i, trans_z_i},
                       '{point_x_i, point_y_i, point_z_i}, obs_u_i, obs_v_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(res_u_o, res_v_o, in_front_o);
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall pattern, mostly short runs and a few long ones
  always @(negedge clk_i) begin
    if (quiet_stall) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 7) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(8, 40))
                                                 : int'($urandom_range(0, 2));
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // write to an index past the register list, must be ignored
  task automatic write_bad_index();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= 3'd6 + 3'($urandom_range(0, 1));
    cfg_data_i <= $urandom;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // send one input beat, hold it until accepted
  task automatic send(logic signed [31:0] q[4], logic signed [31:0] t[3],
                      logic signed [31:0] p[3], logic signed [31:0] ou,
                      logic signed [31:0] ov);
    int g;
    rot_qx_i <= q[0]; rot_qy_i <= q[1]; rot_qz_i <= q[2]; rot_qw_i <= q[3];
    trans_x_i <= t[0]; trans_y_i <= t[1]; trans_z_i <= t[2];
    point_x_i <= p[0]; point_y_i <= p[1]; point_z_i <= p[2];
    obs_u_i <= ou; obs_v_i <= ov;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    @(negedge clk_i);
    g = ($urandom_range(0, 1) == 1) ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // wait for the pipeline to drain
  task automatic drain();
    in_valid_i <= 1'b0;
    quiet_stall = 1'b1;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    quiet_stall = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_small(int range);
    return 32'($urandom_range(0, 2 * range)) - range;
  endfunction

  // random beat, mostly a plausible view, sometimes raw noise
  task automatic send_random();
    logic signed [31:0] q[4], t[3], p[3];
    logic signed [31:0] ou, ov;
    real a, b, c, d, n;
    if ($urandom_range(0, 4) == 0) begin
      foreach (q[i]) q[i] = $urandom_range(0, 3) == 0 ? $urandom : rand_small(OneQ30);
      foreach (t[i]) t[i] = $urandom;
      foreach (p[i]) p[i] = $urandom;
      ou = $urandom;
      ov = $urandom;
    end else begin
      a = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
      b = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
      c = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
      d = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1e-6;
      q[0] = $rtoi(a / n * 1073741823.0);
      q[1] = $rtoi(b / n * 1073741823.0);
      q[2] = $rtoi(c / n * 1073741823.0);
      q[3] = $rtoi(d / n * 1073741823.0);
      foreach (t[i]) t[i] = rand_small(32'sd1 <<< 20);
      foreach (p[i]) p[i] = rand_small(32'sd1 <<< 22);
      ou = rand_small(32'sd1 <<< 27);
      ov = rand_small(32'sd1 <<< 27);
    end
    send(q, t, p, ou, ov);
  endtask

  initial begin
    logic signed [31:0] qid[4], qneg[4], t0[3], p0[3], tmax[3], tmin[3], pz[3];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed beats with reset registers
    qid = '{0, 0, 0, OneQ30};
    qneg = '{-OneQ30, -OneQ30, -OneQ30, -OneQ30};
    t0 = '{0, 0, 0};
    pz = '{32'sh0001_0000, -32'sh0002_0000, 32'sh0005_0000};
    tmax = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    tmin = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send(qid, t0, pz, 32'sd0, 32'sd0);
    send(qid, t0, '{0, 0, 6554}, 32'sd1, 32'sd1);
    send(qid, t0, '{0, 0, 6555}, 32'sh7fff_ffff, 32'sh8000_0000);
    send(qid, t0, '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd6555}, 0, 0);
    send(qid, tmax, tmax, 32'sh8000_0000, 32'sh7fff_ffff);
    send(qid, tmin, tmin, 0, 0);
    send(qneg, t0, pz, 0, 0);
    send('{OneQ30, OneQ30, OneQ30, OneQ30}, tmax, tmin, -1, -1);
    send('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000},
         t0, pz, 0, 0);
    send('{OneQ30, 0, 0, 0}, t0, '{0, 0, -32'sh0005_0000}, 0, 0);
    send(qid, '{0, 0, 32'sh0000_8000}, '{32'sh0fff_0000, -32'sh0fff_0000, 0}, 0, 0);
    send(qid, t0, '{-32'sh0000_0001, 32'sh0000_0001, 32'sh0001_0000}, 5, -5);
    drain();

    // extreme intrinsics
    write_reg(CfgFocalX, 32'hffff_ffff);
    write_reg(CfgFocalY, 32'h0);
    write_reg(CfgCenterX, 32'h8000_0000);
    write_reg(CfgCenterY, 32'h7fff_ffff);
    write_reg(CfgSkew, 32'h8000_0000);
    write_reg(CfgMinDepth, 32'h0);
    write_bad_index();
    send(qid, t0, pz, 0, 0);
    send(qid, t0, '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd1}, 0, 0);
    send(qid, t0, '{32'sh8000_0000, 32'sh8000_0000, 32'sd1}, 32'sh7fff_ffff, 0);
    send(qid, t0, '{0, 0, 0}, 0, 0);
    drain();
    write_reg(CfgSkew, 32'h7fff_ffff);
    write_reg(CfgMinDepth, 32'h7fff_ffff);
    send(qid, tmax, tmax, 0, 0);
    send(qid, t0, pz, 0, 0);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_reg(CfgFocalX, FocalXRst);
        write_reg(CfgFocalY, FocalYRst);
        write_reg(CfgCenterX, CenterXRst);
        write_reg(CfgCenterY, CenterYRst);
        write_reg(CfgSkew, SkewRst);
        write_reg(CfgMinDepth, MinDepthRst);
      end else if (ph == 5) begin
        write_reg(CfgFocalX, 32'h7fff_ffff);
        write_reg(CfgFocalY, 32'h7fff_ffff);
        write_reg(CfgSkew, 32'h8000_0000);
        write_reg(CfgMinDepth, 32'd1);
      end else begin
        write_reg(CfgFocalX, $urandom_range(0, 32'h0800_0000));
        write_reg(CfgFocalY, $urandom_range(0, 32'h0800_0000));
        write_reg(CfgCenterX, $urandom);
        write_reg(CfgCenterY, $urandom);
        write_reg(CfgSkew, rand_small(32'sh0010_0000));
        write_reg(CfgMinDepth, $urandom_range(0, 32'h0010_0000));
        if (ph == 3) write_bad_index();
      end
      repeat (215) send_random();
      drain();
    end

    $display("sent %0d beats, checked %0d results, %0d in front of the camera",
             n_sent, board.n_checked, board.n_front);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/prr_pkg.sv
hw/rtl/pinhole_reprojection_residual.sv
hw/rtl/prr_checker.sv
tb/sv/testbench.sv
